### sv/ssq_pkg.sv
// ----------------------------------------------------------------------------
// ssq_pkg: shared definitions for the stereo square-root saturator
// Sample widths, square-root cell word layout and pipeline latency.
// ----------------------------------------------------------------------------
package ssq_pkg;

	localparam int SAMPLE_BITS = 24;
	localparam int FRAC_BITS   = SAMPLE_BITS - 1;
	localparam int GAIN_BITS   = 20;
	localparam int GAIN_FRAC   = 16;
	localparam logic [GAIN_BITS-1:0] GAIN_RESET = GAIN_BITS'(65536);

	// Product of magnitude and gain, and the radicand handed to the root cells.
	localparam int PROD_BITS = SAMPLE_BITS + GAIN_BITS;
	localparam int DIFF_BITS = FRAC_BITS + GAIN_FRAC;
	localparam int RAD_BITS  = 2 * SAMPLE_BITS;
	localparam int RAD_SHIFT = FRAC_BITS - 14;
	localparam int ROOT_BITS = SAMPLE_BITS;
	localparam int REM_BITS  = SAMPLE_BITS + 2;

	localparam logic [PROD_BITS-1:0] PROD_ONE = PROD_BITS'(1) << DIFF_BITS;

	// Front stages, one cell per root bit, then the output register.
	localparam int LATENCY = SAMPLE_BITS + 4;

	typedef struct packed {
		logic [REM_BITS-1:0]  rem;
		logic [ROOT_BITS-1:0] root;
		logic [RAD_BITS-1:0]  rad;
		logic                 neg;
		logic                 zero;
		logic                 sat;
	} cell_t;

endpackage

### sv/stereo_sqrt_console_saturator.sv
// ----------------------------------------------------------------------------
// stereo_sqrt_console_saturator: stereo soft saturator
// Gain, clamp and square-root shaping of both channels of a frame.
//
//   channel   signals                        direction
//   request   start, busy, left_in, right_in in; busy out
//   result    strobe, left_out, right_out    out
//   config    input_gain_we, input_gain      in
//
// One frame is taken every cycle; busy stays low. A result passes
// through the front stages, one root cell per output bit and the
// output register. Reset clears the valid pipeline and sets the
// gain to unity. The receiver cannot stall.
// ----------------------------------------------------------------------------
module stereo_sqrt_console_saturator (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic signed [ssq_pkg::SAMPLE_BITS-1:0] left_in,
	input  logic signed [ssq_pkg::SAMPLE_BITS-1:0] right_in,
	output logic                                   strobe,
	output logic signed [ssq_pkg::SAMPLE_BITS-1:0] left_out,
	output logic signed [ssq_pkg::SAMPLE_BITS-1:0] right_out,
	input  logic                                   input_gain_we,
	input  logic [ssq_pkg::GAIN_BITS-1:0]          input_gain
);

	logic [ssq_pkg::GAIN_BITS-1:0] gain_q;
	logic [ssq_pkg::LATENCY-1:0]   valid_q;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q  <= ssq_pkg::GAIN_RESET;
			valid_q <= '0;
		end else begin
			if (input_gain_we) begin
				gain_q <= input_gain;
			end
			valid_q <= {valid_q[ssq_pkg::LATENCY-2:0], start};
		end
	end

	assign strobe = valid_q[ssq_pkg::LATENCY-1];

	ssq_chan u_left (
		.clk    (clk),
		.gain   (gain_q),
		.sample (left_in),
		.shaped (left_out)
	);

	ssq_chan u_right (
		.clk    (clk),
		.gain   (gain_q),
		.sample (right_in),
		.shaped (right_out)
	);

endmodule

### sv/ssq_sqrt_cell.sv
// ----------------------------------------------------------------------------
// ssq_sqrt_cell: one bit of a pipelined square root
// Brings down two radicand bits, tries the next root bit and registers
// the partial remainder and root for the following cell.
// ----------------------------------------------------------------------------
module ssq_sqrt_cell (
	input  logic           clk,
	input  ssq_pkg::cell_t cell_in,
	output ssq_pkg::cell_t cell_out
);

	logic [ssq_pkg::REM_BITS-1:0] rem_sh;
	logic [ssq_pkg::REM_BITS-1:0] trial;
	ssq_pkg::cell_t cell_d;
	ssq_pkg::cell_t cell_q;

	always_comb begin
		rem_sh = {cell_in.rem[ssq_pkg::REM_BITS-3:0],
			cell_in.rad[ssq_pkg::RAD_BITS-1 -: 2]};
		trial  = {cell_in.root, 2'b01};
		cell_d = cell_in;
		cell_d.rad = {cell_in.rad[ssq_pkg::RAD_BITS-3:0], 2'b00};
		if (rem_sh >= trial) begin
			cell_d.rem  = rem_sh - trial;
			cell_d.root = {cell_in.root[ssq_pkg::ROOT_BITS-2:0], 1'b1};
		end else begin
			cell_d.rem  = rem_sh;
			cell_d.root = {cell_in.root[ssq_pkg::ROOT_BITS-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		cell_q <= cell_d;
	end

	assign cell_out = cell_q;

endmodule

### sv/ssq_chan.sv
// ----------------------------------------------------------------------------
// ssq_chan: datapath for one audio channel
// Magnitude, gain multiply, radicand, a row of root cells and the final
// sign and saturation stage.
// ----------------------------------------------------------------------------
module ssq_chan (
	input  logic                                 clk,
	input  logic [ssq_pkg::GAIN_BITS-1:0]        gain,
	input  logic signed [ssq_pkg::SAMPLE_BITS-1:0] sample,
	output logic signed [ssq_pkg::SAMPLE_BITS-1:0] shaped
);

	localparam int S = ssq_pkg::SAMPLE_BITS;

	logic [S-1:0]                  mag_s1;
	logic                          neg_s1;
	logic [ssq_pkg::PROD_BITS-1:0] prod_s2;
	logic                          neg_s2;
	ssq_pkg::cell_t                cell_s3;
	ssq_pkg::cell_t                chain [0:S];
	logic [ssq_pkg::DIFF_BITS-1:0] diff;
	logic [S:0]                    ymag;
	logic [S-1:0]                  yval;
	logic signed [S-1:0]           shaped_q;

	always_ff @(posedge clk) begin
		neg_s1  <= sample[S-1];
		mag_s1  <= sample[S-1] ? (S'(0) - S'(sample)) : S'(sample);
		neg_s2  <= neg_s1;
		prod_s2 <= ssq_pkg::PROD_BITS'(mag_s1) * ssq_pkg::PROD_BITS'(gain);
	end

	assign diff = ssq_pkg::DIFF_BITS'(ssq_pkg::PROD_ONE - prod_s2);

	always_ff @(posedge clk) begin
		cell_s3.rem  <= '0;
		cell_s3.root <= '0;
		cell_s3.rad  <= ssq_pkg::RAD_BITS'(diff) << ssq_pkg::RAD_SHIFT;
		cell_s3.neg  <= neg_s2;
		cell_s3.zero <= (prod_s2 == '0);
		cell_s3.sat  <= (prod_s2 >= ssq_pkg::PROD_ONE);
	end

	assign chain[0] = cell_s3;

	for (genvar i = 0; i < S; i++) begin : g_cell
		ssq_sqrt_cell u_cell (
			.clk      (clk),
			.cell_in  (chain[i]),
			.cell_out (chain[i+1])
		);
	end

	// Magnitude is (2 - root) / 2 in output units, full scale when clamped.
	always_comb begin
		if (chain[S].zero) begin
			ymag = '0;
		end else if (chain[S].sat) begin
			ymag = (S+1)'(1) << (S - 1);
		end else begin
			ymag = (((S+1)'(1) << S) - (S+1)'(chain[S].root)) >> 1;
		end
		if (chain[S].neg) begin
			yval = S'(0) - S'(ymag);
		end else if (ymag >= ((S+1)'(1) << (S - 1))) begin
			yval = (S'(1) << (S - 1)) - S'(1);
		end else begin
			yval = S'(ymag);
		end
	end

	always_ff @(posedge clk) begin
		shaped_q <= signed'(yval);
	end

	assign shaped = shaped_q;

endmodule

### sv/ssq_checker.sv
// ----------------------------------------------------------------------------
// ssq_checker: port-level checks for the stereo saturator
// Busy never raised, latency, zero in gives zero out on the left channel, and sign of non-negative right samples.
// ----------------------------------------------------------------------------
module ssq_checker (
	input logic                                   clk,
	input logic                                   arst_n,
	input logic                                   start,
	input logic                                   busy,
	input logic signed [ssq_pkg::SAMPLE_BITS-1:0] left_in,
	input logic signed [ssq_pkg::SAMPLE_BITS-1:0] right_in,
	input logic                                   strobe,
	input logic signed [ssq_pkg::SAMPLE_BITS-1:0] left_out,
	input logic signed [ssq_pkg::SAMPLE_BITS-1:0] right_out
);

	localparam int S = ssq_pkg::SAMPLE_BITS;

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##(ssq_pkg::LATENCY) strobe)
		else $error("result strobe missing");

	a_zero_left: assert property (@(posedge clk) disable iff (!arst_n)
		(start && left_in == '0) |-> ##(ssq_pkg::LATENCY) (left_out == '0))
		else $error("zero sample not zero");

	a_sign_right: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !right_in[S-1]) |-> ##(ssq_pkg::LATENCY) !right_out[S-1])
		else $error("positive sample came out negative");

endmodule

bind stereo_sqrt_console_saturator ssq_checker u_ssq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.left_in   (left_in),
	.right_in  (right_in),
	.strobe    (strobe),
	.left_out  (left_out),
	.right_out (right_out)
);

### verif/stereo_sqrt_console_saturator_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stereo_sqrt_console_saturator_checker: result predictor and comparator
// Watches the request, result and gain channels, predicts each shaped frame
// and compares it with the next result in order.
// ----------------------------------------------------------------------------
module stereo_sqrt_console_saturator_checker (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	input  logic                                   busy,
	input  logic signed [ssq_pkg::SAMPLE_BITS-1:0] left_in,
	input  logic signed [ssq_pkg::SAMPLE_BITS-1:0] right_in,
	input  logic                                   strobe,
	input  logic signed [ssq_pkg::SAMPLE_BITS-1:0] left_out,
	input  logic signed [ssq_pkg::SAMPLE_BITS-1:0] right_out,
	input  logic                                   input_gain_we,
	input  logic [ssq_pkg::GAIN_BITS-1:0]          input_gain,
	output int                                     fail_count,
	output int                                     pending,
	output int                                     frames_seen
);

	typedef struct packed {
		logic [ssq_pkg::SAMPLE_BITS-1:0] left;
		logic [ssq_pkg::SAMPLE_BITS-1:0] right;
	} frame_t;

	frame_t                          shaped_frames[$];
	logic [ssq_pkg::GAIN_BITS-1:0]   gain_now;

	function automatic logic [63:0] isqrt(logic [63:0] n);
		logic [63:0] r;
		logic [63:0] b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n)
			b = b >> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic logic [ssq_pkg::SAMPLE_BITS-1:0] shape_sample(
			logic [ssq_pkg::SAMPLE_BITS-1:0] x, logic [ssq_pkg::GAIN_BITS-1:0] g);
		logic        neg;
		logic [63:0] mag;
		logic [63:0] u;
		logic [63:0] full;
		logic [63:0] unity;
		logic [63:0] ymag;
		neg   = x[ssq_pkg::SAMPLE_BITS-1];
		full  = 64'd1 << ssq_pkg::FRAC_BITS;
		unity = 64'd1 << (ssq_pkg::FRAC_BITS + ssq_pkg::GAIN_FRAC);
		mag   = neg ? ((64'd1 << ssq_pkg::SAMPLE_BITS) - 64'(x)) : 64'(x);
		u     = mag * 64'(g);
		if (u == 0)
			ymag = 0;
		else if (u >= unity)
			ymag = full;
		else
			ymag = ((full << 1) - isqrt((unity - u) << (ssq_pkg::FRAC_BITS - 14))) >> 1;
		if (ymag > full)
			ymag = full;
		if (neg)
			return ssq_pkg::SAMPLE_BITS'((64'd1 << ssq_pkg::SAMPLE_BITS) - ymag);
		if (ymag >= full)
			ymag = full - 1;
		return ymag[ssq_pkg::SAMPLE_BITS-1:0];
	endfunction

	assign pending = shaped_frames.size();

	always @(posedge clk or negedge arst_n) begin
		frame_t want;
		if (!arst_n) begin
			gain_now    <= ssq_pkg::GAIN_RESET;
			fail_count  <= 0;
			frames_seen <= 0;
			shaped_frames.delete();
		end else begin
			if (strobe) begin
				frames_seen <= frames_seen + 1;
				if (shaped_frames.size() == 0) begin
					$display("%0t: unexpected result left %0d right %0d", $time,
						left_out, right_out);
					fail_count <= fail_count + 1;
				end else begin
					want = shaped_frames.pop_front();
					if (want.left !== left_out || want.right !== right_out) begin
						$display("%0t: expected left %0d right %0d, got left %0d right %0d",
							$time, $signed(want.left), $signed(want.right),
							left_out, right_out);
						fail_count <= fail_count + 1;
					end
				end
			end
			// The prediction uses the gain held before this edge.
			if (start && !busy)
				shaped_frames.push_back({shape_sample(left_in, gain_now),
					shape_sample(right_in, gain_now)});
			if (input_gain_we)
				gain_now <= input_gain;
		end
	end
endmodule

### verif/stereo_sqrt_console_saturator_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stereo_sqrt_console_saturator_test: top level of the saturator testbench
// Drives directed and random stereo frames under several gain settings with
// random gaps, and reports the verdict from the checker's failure count and pending results.
// ----------------------------------------------------------------------------
module stereo_sqrt_console_saturator_test;

	logic                                   clk;
	logic                                   arst_n;
	logic                                   start;
	logic                                   busy;
	logic signed [ssq_pkg::SAMPLE_BITS-1:0] left_in;
	logic signed [ssq_pkg::SAMPLE_BITS-1:0] right_in;
	logic                                   strobe;
	logic signed [ssq_pkg::SAMPLE_BITS-1:0] left_out;
	logic signed [ssq_pkg::SAMPLE_BITS-1:0] right_out;
	logic                                   input_gain_we;
	logic [ssq_pkg::GAIN_BITS-1:0]          input_gain;
	int                                     fail_count;
	int                                     pending;
	int                                     frames_seen;
	int                                     frames_sent;

	stereo_sqrt_console_saturator i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.left_in(left_in), .right_in(right_in), .strobe(strobe),
		.left_out(left_out), .right_out(right_out),
		.input_gain_we(input_gain_we), .input_gain(input_gain)
	);

	stereo_sqrt_console_saturator_checker i_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.left_in(left_in), .right_in(right_in), .strobe(strobe),
		.left_out(left_out), .right_out(right_out),
		.input_gain_we(input_gain_we), .input_gain(input_gain),
		.fail_count(fail_count), .pending(pending), .frames_seen(frames_seen)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("simulation failed");
		$finish;
	end

	// Send one request, holding start until it is taken, then an optional gap.
	task automatic send_frame(logic [ssq_pkg::SAMPLE_BITS-1:0] l,
			logic [ssq_pkg::SAMPLE_BITS-1:0] r, int gap);
		start    <= 1'b1;
		left_in  <= l;
		right_in <= r;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		frames_sent++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain_and_set_gain(logic [ssq_pkg::GAIN_BITS-1:0] g);
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		input_gain_we <= 1'b1;
		input_gain    <= g;
		@(posedge clk);
		input_gain_we <= 1'b0;
	endtask

	function automatic logic [ssq_pkg::SAMPLE_BITS-1:0] random_sample();
		case ($urandom_range(0, 5))
			0: return ssq_pkg::SAMPLE_BITS'($urandom_range(0, 15));
			1: return -ssq_pkg::SAMPLE_BITS'($urandom_range(0, 15));
			2: return {1'b0, {(ssq_pkg::SAMPLE_BITS-1){1'b1}}}
				- ssq_pkg::SAMPLE_BITS'($urandom_range(0, 15));
			3: return {1'b1, {(ssq_pkg::SAMPLE_BITS-1){1'b0}}}
				+ ssq_pkg::SAMPLE_BITS'($urandom_range(0, 15));
			default: return ssq_pkg::SAMPLE_BITS'($urandom);
		endcase
	endfunction

	function automatic int random_gap();
		return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
	endfunction

	initial begin
		logic [ssq_pkg::GAIN_BITS-1:0] gain_plan[8];
		logic [ssq_pkg::SAMPLE_BITS-1:0] edge_vals[6];
		logic [ssq_pkg::GAIN_BITS-1:0] gain_pick;
		int burst;
		gain_plan = '{20'd65536, 20'd0, 20'hFFFFF, 20'd1, 20'd32768, 20'd131072,
			20'd65535, 20'd70000};
		edge_vals = '{24'h000000, 24'h7FFFFF, 24'h800000, 24'h000001, 24'hFFFFFF,
			24'h400000};
		frames_sent   = 0;
		arst_n        = 1'b0;
		start         = 1'b0;
		left_in       = '0;
		right_in      = '0;
		input_gain_we = 1'b0;
		input_gain    = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed frames at reset gain: zero, both full scales, smallest steps, half scale.
		foreach (edge_vals[i])
			send_frame(edge_vals[i], edge_vals[(i + 1) % 6], i % 2);
		send_frame(24'h7FFFFF, 24'h800000, 0);

		// Zero gain, largest gain (over-range clamp) and a fine gain.
		for (int g = 1; g < 4; g++) begin
			drain_and_set_gain(gain_plan[g]);
			foreach (edge_vals[i])
				send_frame(edge_vals[i], edge_vals[5 - i], 0);
		end

		for (int phase = 0; phase < 13; phase++) begin
			gain_pick = (phase < 8) ? gain_plan[phase] : ssq_pkg::GAIN_BITS'($urandom);
			drain_and_set_gain(gain_pick);
			for (int k = 0; k < 100; k++) begin
				// Stretches of back-to-back requests between gappy ones.
				burst = ($urandom_range(0, 4) == 0);
				send_frame(random_sample(), random_sample(), burst ? 0 : random_gap());
			end
		end

		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (ssq_pkg::LATENCY + 4) @(posedge clk);
		$display("Sent %0d frames over %0d gain settings; %0d results checked.",
			frames_sent, 17, frames_seen);
		if (fail_count == 0 && pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule

### sim.f
sv/ssq_pkg.sv
sv/ssq_sqrt_cell.sv
sv/ssq_chan.sv
sv/stereo_sqrt_console_saturator.sv
sv/ssq_checker.sv
verif/stereo_sqrt_console_saturator_checker.sv
verif/stereo_sqrt_console_saturator_test.sv
